/* sv/ddo_pkg.sv */
// shared types, constants and helper functions for the differential drive odometry block
// no dependencies; compile first
package ddo_pkg;

    localparam int ATAN_COUNT = 24;
    localparam int ITER_W     = 5;
    localparam int CW         = 33;
    localparam int MA_W       = 34;
    localparam int MB_W       = 31;
    localparam int PROD_W     = MA_W + MB_W;
    localparam int SPD_W      = 17;
    localparam int TRIG_W     = 18;

    localparam logic signed [CW-1:0]   GAIN_INV_Q30   = 33'sd652032875;
    localparam logic signed [CW-1:0]   QUARTER_TURN   = 33'sd1073741824;
    localparam logic signed [CW-1:0]   HALF_TURN      = 33'sd2147483648;
    localparam logic signed [MB_W-1:0] RAD_TO_BAM_Q16 = 31'sd683565276;
    localparam logic [15:0]            INV_TRACK_RST  = 16'd8192;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_ROT,
        ST_FIX,
        ST_MUL,
        ST_DONE
    } state_t;

    // multiplier schedule, one product per step
    typedef enum logic [2:0]
    {
        MS_TRACK,
        MS_SPEED,
        MS_TURN,
        MS_COS,
        MS_BAM,
        MS_SIN,
        MS_LAST
    } mstep_t;

    function automatic logic signed [CW-1:0] atan_bam(input logic [ITER_W-1:0] i);
        logic signed [CW-1:0] a;
        case (i)
            5'd0:    a = 33'sh020000000;
            5'd1:    a = 33'sh012E4051E;
            5'd2:    a = 33'sh009FB385B;
            5'd3:    a = 33'sh0051111D4;
            5'd4:    a = 33'sh0028B0D43;
            5'd5:    a = 33'sh00145D7E1;
            5'd6:    a = 33'sh000A2F61E;
            5'd7:    a = 33'sh000517C55;
            5'd8:    a = 33'sh00028BE53;
            5'd9:    a = 33'sh000145F2F;
            5'd10:   a = 33'sh0000A2F98;
            5'd11:   a = 33'sh0000517CC;
            5'd12:   a = 33'sh000028BE6;
            5'd13:   a = 33'sh0000145F3;
            5'd14:   a = 33'sh00000A2FA;
            5'd15:   a = 33'sh00000517D;
            5'd16:   a = 33'sh0000028BE;
            5'd17:   a = 33'sh00000145F;
            5'd18:   a = 33'sh000000A30;
            5'd19:   a = 33'sh000000518;
            5'd20:   a = 33'sh00000028C;
            5'd21:   a = 33'sh000000146;
            5'd22:   a = 33'sh0000000A3;
            5'd23:   a = 33'sh000000051;
            default: a = '0;
        endcase
        return a;
    endfunction

    // round to nearest, ties away from zero, by a constant shift
    function automatic logic signed [PROD_W-1:0] round_shift(
        input logic signed [PROD_W-1:0] v,
        input int unsigned              s
    );
        logic signed [PROD_W-1:0] half;
        logic signed [PROD_W-1:0] sum;
        half = 65'sd1 <<< (s - 1);
        if (v[PROD_W-1])
        begin
            sum = v + half - 65'sd1;
        end
        else
        begin
            sum = v + half;
        end
        return sum >>> s;
    endfunction

endpackage

/* sv/ddo_in_if.sv */
// input item channel: wheel speeds and time step
// uses no package
interface ddo_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic [15:0]        time_step;

    modport source (output valid, output left_speed, output right_speed, output time_step,
                    input ready);
    modport sink   (input valid, input left_speed, input right_speed, input time_step,
                    output ready);
endinterface

/* sv/ddo_out_if.sv */
// result item channel: pose after one step
// uses no package
interface ddo_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        heading;

    modport source (output valid, output pos_x, output pos_y, output heading, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input heading, output ready);
endinterface

/* sv/differential_drive_odometry.sv */
// Differential drive odometry, one Euler pose step per item. An item is taken only while the
// block is idle, and each item then passes through the rotation, fix, multiply and done states:
// the CORDIC rotation runs one iteration a cycle on one shift/add unit, then a single shared
// 34x31 multiplier does six products, each registered before it is used. The new pose is
// held in an output register, so the next item can be taken while a result waits.
// Depends on ddo_pkg, ddo_in_if and ddo_out_if.
module differential_drive_odometry #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    ddo_in_if.sink      in_item,
    ddo_out_if.source   out_item
);

    localparam int NSTEP = (CORDIC_STEPS < ddo_pkg::ATAN_COUNT) ?
                           CORDIC_STEPS : ddo_pkg::ATAN_COUNT;
    localparam logic [ddo_pkg::ITER_W-1:0] LAST_ITER = ddo_pkg::ITER_W'(NSTEP - 1);

    ddo_pkg::state_t state_reg, state_next;
    ddo_pkg::mstep_t mstep_reg, mstep_next;
    logic [ddo_pkg::ITER_W-1:0] iter_reg, iter_next;
    logic [15:0] itrack_reg;
    logic        out_valid_reg, out_valid_next;

    logic signed [31:0] acc_x_reg, acc_x_next;
    logic signed [31:0] acc_y_reg, acc_y_next;
    logic [15:0]        acc_hd_reg, acc_hd_next;

    logic signed [ddo_pkg::SPD_W-1:0]  v13_reg, v13_next;
    logic signed [ddo_pkg::SPD_W-1:0]  dlr_reg, dlr_next;
    logic [15:0]                       dt_reg, dt_next;
    logic signed [ddo_pkg::CW-1:0]     cx_reg, cx_next;
    logic signed [ddo_pkg::CW-1:0]     cy_reg, cy_next;
    logic signed [ddo_pkg::CW-1:0]     cz_reg, cz_next;
    logic                              flip_reg, flip_next;
    logic signed [ddo_pkg::TRIG_W-1:0] cos_reg, cos_next;
    logic signed [ddo_pkg::TRIG_W-1:0] sin_reg, sin_next;
    logic signed [ddo_pkg::MA_W-1:0]   pv_reg, pv_next;
    logic signed [ddo_pkg::MA_W-1:0]   pw_reg, pw_next;
    logic signed [ddo_pkg::MA_W-1:0]   rad_reg, rad_next;
    logic signed [ddo_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic signed [31:0]                out_x_reg, out_x_next;
    logic signed [31:0]                out_y_reg, out_y_next;
    logic [15:0]                       out_hd_reg, out_hd_next;

    logic                              take_item;
    logic                              load_out;
    logic signed [ddo_pkg::CW-1:0]     z_raw;
    logic signed [ddo_pkg::CW-1:0]     z_fold;
    logic                              fold;
    logic signed [ddo_pkg::CW-1:0]     xs, ys, atan_val;
    logic signed [ddo_pkg::CW-1:0]     x_fin, y_fin;
    logic signed [ddo_pkg::PROD_W-1:0] cos_wide, sin_wide;
    logic signed [ddo_pkg::MA_W-1:0]   mul_a;
    logic signed [ddo_pkg::MB_W-1:0]   mul_b;
    logic signed [ddo_pkg::PROD_W-1:0] product;
    logic signed [ddo_pkg::PROD_W-1:0] rnd20, rnd27, rnd34;

    assign take_item = in_item.valid && in_item.ready;
    assign load_out  = (state_reg == ddo_pkg::ST_DONE) && (!out_valid_reg || out_item.ready);

    // fold heading into a quarter turn either side of zero
    always_comb
    begin
        z_raw  = {acc_hd_reg[15], acc_hd_reg, 16'b0};
        z_fold = z_raw;
        fold   = 1'b0;
        if (z_raw > ddo_pkg::QUARTER_TURN)
        begin
            z_fold = z_raw - ddo_pkg::HALF_TURN;
            fold   = 1'b1;
        end
        else if (z_raw < -ddo_pkg::QUARTER_TURN)
        begin
            z_fold = z_raw + ddo_pkg::HALF_TURN;
            fold   = 1'b1;
        end
    end

    assign xs       = cx_reg >>> iter_reg;
    assign ys       = cy_reg >>> iter_reg;
    assign atan_val = ddo_pkg::atan_bam(iter_reg);
    assign x_fin    = flip_reg ? -cx_reg : cx_reg;
    assign y_fin    = flip_reg ? -cy_reg : cy_reg;
    assign cos_wide = ddo_pkg::round_shift(ddo_pkg::PROD_W'(x_fin), 14);
    assign sin_wide = ddo_pkg::round_shift(ddo_pkg::PROD_W'(y_fin), 14);

    // operand select for the shared multiplier
    always_comb
    begin
        case (mstep_reg)
            ddo_pkg::MS_TRACK:
            begin
                mul_a = ddo_pkg::MA_W'(dlr_reg);
                mul_b = ddo_pkg::MB_W'({1'b0, itrack_reg});
            end
            ddo_pkg::MS_SPEED:
            begin
                mul_a = ddo_pkg::MA_W'(v13_reg);
                mul_b = ddo_pkg::MB_W'({1'b0, dt_reg});
            end
            ddo_pkg::MS_TURN:
            begin
                mul_a = pw_reg;
                mul_b = ddo_pkg::MB_W'({1'b0, dt_reg});
            end
            ddo_pkg::MS_COS:
            begin
                mul_a = pv_reg;
                mul_b = ddo_pkg::MB_W'(cos_reg);
            end
            ddo_pkg::MS_BAM:
            begin
                mul_a = rad_reg;
                mul_b = ddo_pkg::RAD_TO_BAM_Q16;
            end
            ddo_pkg::MS_SIN:
            begin
                mul_a = pv_reg;
                mul_b = ddo_pkg::MB_W'(sin_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = mul_a * mul_b;
    assign rnd20   = ddo_pkg::round_shift(prod_reg, 20);
    assign rnd27   = ddo_pkg::round_shift(prod_reg, 27);
    assign rnd34   = ddo_pkg::round_shift(prod_reg, 34);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ddo_pkg::ST_IDLE:
            begin
                if (take_item)
                begin
                    state_next = ddo_pkg::ST_ROT;
                end
            end
            ddo_pkg::ST_ROT:
            begin
                if (iter_reg == LAST_ITER)
                begin
                    state_next = ddo_pkg::ST_FIX;
                end
            end
            ddo_pkg::ST_FIX:
            begin
                state_next = ddo_pkg::ST_MUL;
            end
            ddo_pkg::ST_MUL:
            begin
                if (mstep_reg == ddo_pkg::MS_LAST)
                begin
                    state_next = ddo_pkg::ST_DONE;
                end
            end
            ddo_pkg::ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ddo_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ddo_pkg::ST_IDLE;
            end
        endcase
    end

    // handshake outputs
    always_comb
    begin
        in_item.ready    = (state_reg == ddo_pkg::ST_IDLE);
        out_item.valid   = out_valid_reg;
        out_item.pos_x   = out_x_reg;
        out_item.pos_y   = out_y_reg;
        out_item.heading = out_hd_reg;
    end

    // datapath
    always_comb
    begin
        iter_next      = iter_reg;
        mstep_next     = mstep_reg;
        acc_x_next     = acc_x_reg;
        acc_y_next     = acc_y_reg;
        acc_hd_next    = acc_hd_reg;
        v13_next       = v13_reg;
        dlr_next       = dlr_reg;
        dt_next        = dt_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cz_next        = cz_reg;
        flip_next      = flip_reg;
        cos_next       = cos_reg;
        sin_next       = sin_reg;
        pv_next        = pv_reg;
        pw_next        = pw_reg;
        rad_next       = rad_reg;
        prod_next      = prod_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_hd_next    = out_hd_reg;
        out_valid_next = out_valid_reg && !out_item.ready;

        case (state_reg)
            ddo_pkg::ST_IDLE:
            begin
                if (take_item)
                begin
                    v13_next  = ddo_pkg::SPD_W'(in_item.left_speed)
                              + ddo_pkg::SPD_W'(in_item.right_speed);
                    dlr_next  = ddo_pkg::SPD_W'(in_item.right_speed)
                              - ddo_pkg::SPD_W'(in_item.left_speed);
                    dt_next   = in_item.time_step;
                    cx_next   = ddo_pkg::GAIN_INV_Q30;
                    cy_next   = '0;
                    cz_next   = z_fold;
                    flip_next = fold;
                    iter_next = '0;
                end
            end
            ddo_pkg::ST_ROT:
            begin
                if (!cz_reg[ddo_pkg::CW-1])
                begin
                    cx_next = cx_reg - ys;
                    cy_next = cy_reg + xs;
                    cz_next = cz_reg - atan_val;
                end
                else
                begin
                    cx_next = cx_reg + ys;
                    cy_next = cy_reg - xs;
                    cz_next = cz_reg + atan_val;
                end
                iter_next = iter_reg + ddo_pkg::ITER_W'(1);
            end
            ddo_pkg::ST_FIX:
            begin
                cos_next   = cos_wide[ddo_pkg::TRIG_W-1:0];
                sin_next   = sin_wide[ddo_pkg::TRIG_W-1:0];
                mstep_next = ddo_pkg::MS_TRACK;
            end
            ddo_pkg::ST_MUL:
            begin
                prod_next = product;
                // prod_reg holds the product of the previous step
                case (mstep_reg)
                    ddo_pkg::MS_SPEED: pw_next     = prod_reg[ddo_pkg::MA_W-1:0];
                    ddo_pkg::MS_TURN:  pv_next     = prod_reg[ddo_pkg::MA_W-1:0];
                    ddo_pkg::MS_COS:   rad_next    = rnd20[ddo_pkg::MA_W-1:0];
                    ddo_pkg::MS_BAM:   acc_x_next  = acc_x_reg + rnd27[31:0];
                    ddo_pkg::MS_SIN:   acc_hd_next = acc_hd_reg + rnd34[15:0];
                    ddo_pkg::MS_LAST:  acc_y_next  = acc_y_reg + rnd27[31:0];
                    default:           prod_next   = product;
                endcase
                if (mstep_reg != ddo_pkg::MS_LAST)
                begin
                    mstep_next = ddo_pkg::mstep_t'(mstep_reg + 3'd1);
                end
            end
            ddo_pkg::ST_DONE:
            begin
                if (load_out)
                begin
                    out_x_next     = acc_x_reg;
                    out_y_next     = acc_y_reg;
                    out_hd_next    = acc_hd_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                iter_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ddo_pkg::ST_IDLE;
            mstep_reg     <= ddo_pkg::MS_TRACK;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
            itrack_reg    <= ddo_pkg::INV_TRACK_RST;
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
            acc_hd_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mstep_reg     <= mstep_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
            acc_x_reg     <= acc_x_next;
            acc_y_reg     <= acc_y_next;
            acc_hd_reg    <= acc_hd_next;
            if (cfg_we)
            begin
                itrack_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        v13_reg    <= v13_next;
        dlr_reg    <= dlr_next;
        dt_reg     <= dt_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        cz_reg     <= cz_next;
        flip_reg   <= flip_next;
        cos_reg    <= cos_next;
        sin_reg    <= sin_next;
        pv_reg     <= pv_next;
        pw_reg     <= pw_next;
        rad_reg    <= rad_next;
        prod_reg   <= prod_next;
        out_x_reg  <= out_x_next;
        out_y_reg  <= out_y_next;
        out_hd_reg <= out_hd_next;
    end

    // an accepted item keeps the block busy for at least the next cycle
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        take_item |=> !in_item.ready)
        else $error("input taken again right after an item");

    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ddo_pkg::ST_ROT) |-> (iter_reg <= LAST_ITER))
        else $error("cordic iteration count ran past the last step");

    // a fresh result shows the pose just accumulated
    a_result_matches_pose: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (out_hd_reg == acc_hd_reg && out_x_reg == acc_x_reg
                                  && out_y_reg == acc_y_reg))
        else $error("result item differs from accumulated pose");

endmodule

/* tb/testbench.sv */
// self-checking bench for differential_drive_odometry: directed steps, then random phases
// under several inverse_track settings, ending in a full-speed straight run
// depends on ddo_in_if, ddo_out_if and the block itself
module testbench;

    localparam int CORDIC_STEPS = 16;
    localparam int ARCTAN_COUNT = 24;
    localparam longint CORDIC_GAIN_INV = 64'sd652032875;
    localparam longint RAD_TO_BAM = 64'sd683565276;
    localparam longint QUARTER_TURN = 64'sd1 <<< 30;
    localparam longint HALF_TURN = 64'sd1 <<< 31;
    localparam int MAX_PRINTED = 40;
    localparam int RANDOM_PHASES = 7;
    localparam int ITEMS_PER_PHASE = 70;
    localparam int CRUISE_CAP = 92;

    // arctan(2^-i) as 32-bit binary angles
    localparam logic [31:0] ARCTAN_BAM [ARCTAN_COUNT] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [15:0]        heading;
    } pose_t;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic [15:0]        dt;
        logic               typed;
        pose_t              pose;
    } step_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    ddo_in_if  in_ch ();
    ddo_out_if out_ch ();

    differential_drive_odometry #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_item  (in_ch),
        .out_item (out_ch)
    );

    // predicted block state
    logic signed [31:0] odo_x;
    logic signed [31:0] odo_y;
    logic [15:0]        odo_heading;
    logic [15:0]        odo_inv_track;
    int                 wrap_count;

    pose_t pending_poses[$];
    int    mismatch_count;
    int    in_count;
    int    out_count;
    int    setting_count;
    bit    in_steady;
    bit    out_steady;

    step_row_t directed_rows [18];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("timeout: %0d items sent, %0d poses received", in_count, out_count);
        $display("differential_drive_odometry verification failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
        begin
            $display("MISMATCH: %s", msg);
        end
    endtask

    function automatic longint round_half_away(input longint v, input int s);
        longint half;
        half = 64'sd1 <<< (s - 1);
        if (v >= 0)
        begin
            return (v + half) >>> s;
        end
        return -(((-v) + half) >>> s);
    endfunction

    // rotation-mode cordic on the heading, results in Q.30
    function automatic void heading_trig(input logic [15:0] h, output longint c,
                                         output longint s);
        longint z;
        longint xv;
        longint yv;
        longint xs;
        longint ys;
        bit     flip;
        int     n;
        int     i;
        z = longint'($signed({h, 16'h0000}));
        xv = CORDIC_GAIN_INV;
        yv = 0;
        flip = 1'b0;
        if (z > QUARTER_TURN)
        begin
            z = z - HALF_TURN;
            flip = 1'b1;
        end
        else if (z < -QUARTER_TURN)
        begin
            z = z + HALF_TURN;
            flip = 1'b1;
        end
        n = (CORDIC_STEPS < ARCTAN_COUNT) ? CORDIC_STEPS : ARCTAN_COUNT;
        for (i = 0; i < n; i++)
        begin
            xs = xv >>> i;
            ys = yv >>> i;
            if (z >= 0)
            begin
                xv = xv - ys;
                yv = yv + xs;
                z = z - longint'(ARCTAN_BAM[i]);
            end
            else
            begin
                xv = xv + ys;
                yv = yv - xs;
                z = z + longint'(ARCTAN_BAM[i]);
            end
        end
        c = flip ? -xv : xv;
        s = flip ? -yv : yv;
    endfunction

    // one euler step of the pose, using the old heading for the motion
    function automatic pose_t advance_odometry(input logic signed [15:0] l,
                                               input logic signed [15:0] r,
                                               input logic [15:0] dt);
        longint v13;
        longint c30;
        longint s30;
        longint c16;
        longint s16;
        longint sum_x;
        longint sum_y;
        longint rad;
        longint dbam;
        v13 = longint'(l) + longint'(r);
        heading_trig(odo_heading, c30, s30);
        c16 = round_half_away(c30, 14);
        s16 = round_half_away(s30, 14);
        sum_x = longint'(odo_x) + round_half_away(v13 * c16 * longint'(dt), 27);
        sum_y = longint'(odo_y) + round_half_away(v13 * s16 * longint'(dt), 27);
        if (sum_x != longint'($signed(sum_x[31:0])) || sum_y != longint'($signed(sum_y[31:0])))
        begin
            wrap_count++;
        end
        odo_x = sum_x[31:0];
        odo_y = sum_y[31:0];
        rad = round_half_away((longint'(r) - longint'(l)) * longint'(odo_inv_track)
                              * longint'(dt), 20);
        dbam = round_half_away(rad * RAD_TO_BAM, 34);
        odo_heading = odo_heading + dbam[15:0];
        return '{odo_x, odo_y, odo_heading};
    endfunction

    // mostly short, now and then long
    function automatic int idle_gap();
        if ($urandom_range(0, 99) < 85)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [15:0] random_speed();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            1:       return $urandom_range(0, 1) ? 16'sd1 : -16'sd1;
            2, 3, 4: return 16'($urandom);
            default: return 16'($urandom_range(0, 8191) - 4096);
        endcase
    endfunction

    function automatic logic [15:0] random_step();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            1, 2, 3: return 16'($urandom);
            default: return 16'($urandom_range(0, 2047));
        endcase
    endfunction

    task automatic write_inverse_track(input logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        odo_inv_track = value;
        setting_count++;
    endtask

    task automatic send_step(input step_row_t row, input bit last);
        pose_t predicted;
        int    gap;
        in_ch.valid <= 1'b1;
        in_ch.left_speed <= row.left;
        in_ch.right_speed <= row.right;
        in_ch.time_step <= row.dt;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        predicted = advance_odometry(row.left, row.right, row.dt);
        pending_poses.push_back(row.typed ? row.pose : predicted);
        in_count++;
        gap = (!in_steady && $urandom_range(0, 2) == 0) ? idle_gap() : 0;
        if (last || gap > 0)
        begin
            in_ch.valid <= 1'b0;
        end
        repeat (gap) @(posedge clk);
    endtask

    task automatic wait_all_poses();
        while (pending_poses.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // result side: random back-pressure and field-by-field comparison
    initial
    begin : pose_sink
        int    stall_left;
        pose_t got;
        pose_t want;
        stall_left = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                got = '{out_ch.pos_x, out_ch.pos_y, out_ch.heading};
                out_count++;
                if (pending_poses.size() == 0)
                begin
                    report_mismatch($sformatf("pose %0d arrived with none pending", out_count));
                end
                else
                begin
                    want = pending_poses.pop_front();
                    if (got.x !== want.x)
                    begin
                        report_mismatch($sformatf("pose %0d pos_x expected %0d got %0d",
                                                  out_count, want.x, got.x));
                    end
                    if (got.y !== want.y)
                    begin
                        report_mismatch($sformatf("pose %0d pos_y expected %0d got %0d",
                                                  out_count, want.y, got.y));
                    end
                    if (got.heading !== want.heading)
                    begin
                        report_mismatch($sformatf("pose %0d heading expected %0d got %0d",
                                                  out_count, want.heading, got.heading));
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else if (!out_steady && $urandom_range(0, 3) == 0)
            begin
                stall_left = idle_gap() - 1;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        step_row_t row;
        longint    c30;
        longint    s30;
        longint    axis_dir;
        longint    axis_pos;
        int        plan [RANDOM_PHASES];
        int        k;
        int        n;
        int        wraps_before;
        int        sg;
        int        extra;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 16'd0;
        in_ch.valid = 1'b0;
        in_ch.left_speed = 16'sd0;
        in_ch.right_speed = 16'sd0;
        in_ch.time_step = 16'd0;
        odo_x = 32'sd0;
        odo_y = 32'sd0;
        odo_heading = 16'd0;
        odo_inv_track = 16'd8192;
        wrap_count = 0;
        mismatch_count = 0;
        in_count = 0;
        out_count = 0;
        setting_count = 1;
        in_steady = 1'b0;
        out_steady = 1'b0;

        // left, right, time step, typed, typed pose; reset value 2.0 for the track inverse
        directed_rows = '{
            '{16'sd0,      16'sd0,      16'd0,     1'b1, '{32'sd0, 32'sd0, 16'd0}},
            '{16'sh7FFF,   16'sh7FFF,   16'd0,     1'b1, '{32'sd0, 32'sd0, 16'd0}},
            '{16'sh8000,   16'sh7FFF,   16'd0,     1'b1, '{32'sd0, 32'sd0, 16'd0}},
            '{16'sd0,      16'sd0,      16'hFFFF,  1'b1, '{32'sd0, 32'sd0, 16'd0}},
            '{16'sd4096,   16'sd4096,   16'd16384, 1'b0, '0},
            '{-16'sd4096,  16'sd4096,   16'd16384, 1'b0, '0},
            '{16'sh7FFF,   16'sh7FFF,   16'hFFFF,  1'b0, '0},
            '{16'sh8000,   16'sh8000,   16'hFFFF,  1'b0, '0},
            '{16'sh8000,   16'sh7FFF,   16'hFFFF,  1'b0, '0},
            '{16'sh7FFF,   16'sh8000,   16'hFFFF,  1'b0, '0},
            '{16'sd1,      16'sd1,      16'd1,     1'b0, '0},
            '{-16'sd1,     -16'sd1,     16'hFFFF,  1'b0, '0},
            '{-16'sd1,     16'sd0,      16'd1,     1'b0, '0},
            '{16'sd0,      16'sd1,      16'hFFFF,  1'b0, '0},
            '{16'sd16384,  -16'sd16384, 16'd8192,  1'b0, '0},
            '{16'sd12345,  -16'sd23456, 16'd40000, 1'b0, '0},
            '{16'sh8000,   16'sh8000,   16'd1,     1'b0, '0},
            '{16'sh7FFF,   16'sd0,      16'd32768, 1'b0, '0}
        };
        // 0 means no turning at all; -1 means draw a value
        plan = '{65535, 1, 0, -1, 4096, -1, 8192};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < $size(directed_rows); k++)
        begin
            send_step(directed_rows[k], k == $size(directed_rows) - 1);
        end
        wait_all_poses();

        for (k = 0; k < RANDOM_PHASES; k++)
        begin
            write_inverse_track(plan[k] < 0 ? 16'($urandom_range(1, 65535)) : 16'(plan[k]));
            in_steady = ($urandom_range(0, 3) == 0);
            out_steady = ($urandom_range(0, 3) == 0);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                row = '0;
                row.left = random_speed();
                row.right = ($urandom_range(0, 4) == 0) ? row.left : random_speed();
                row.dt = random_step();
                send_step(row, n == ITEMS_PER_PHASE - 1);
            end
            wait_all_poses();
        end

        // straight line at top speed, steered toward the nearer wrap point of the main axis
        write_inverse_track(16'd0);
        in_steady = 1'b1;
        out_steady = 1'b1;
        heading_trig(odo_heading, c30, s30);
        if ((c30 < 0 ? -c30 : c30) >= (s30 < 0 ? -s30 : s30))
        begin
            axis_dir = c30;
            axis_pos = longint'(odo_x);
        end
        else
        begin
            axis_dir = s30;
            axis_pos = longint'(odo_y);
        end
        sg = ((axis_pos >= 0) == (axis_dir >= 0)) ? 1 : -1;
        wraps_before = wrap_count;
        extra = 0;
        n = 0;
        while (n < CRUISE_CAP && extra < 8)
        begin
            row = '0;
            row.left = 16'(sg * int'($urandom_range(30000, 32767)));
            row.right = 16'(sg * int'($urandom_range(30000, 32767)));
            row.dt = 16'($urandom_range(60000, 65535));
            n++;
            if (wrap_count != wraps_before)
            begin
                extra++;
            end
            send_step(row, n == CRUISE_CAP || extra == 8);
        end
        wait_all_poses();

        repeat (60) @(posedge clk);
        $display("%0d steps in, %0d poses out, %0d track settings, %0d position wraps",
                 in_count, out_count, setting_count, wrap_count);
        $display("%0d mismatches", mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("differential_drive_odometry verification clean");
        end
        else
        begin
            $display("differential_drive_odometry verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
sv/ddo_pkg.sv
sv/ddo_in_if.sv
sv/ddo_out_if.sv
sv/differential_drive_odometry.sv
tb/testbench.sv
